// File: hdl/ppsch_pkg.sv
// Shared types, sizes and helpers for the preemptive priority scheduler.
// Used by the queue cells, the queue chain, the top level and the checker.
// No dependencies.
package ppsch_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int ID_BITS       = 8;
   localparam int PRIO_BITS     = 8;
   localparam int BURST_BITS    = 16;
   localparam int FILL_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int COUNT_BITS    = 32;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 88;

   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   typedef struct packed {
      logic [PRIO_BITS-1:0]  prio;
      logic [ID_BITS-1:0]    id;
      logic [BURST_BITS-1:0] rem;
   } job_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic    valid;
      logic    le;     // holds a job that sorts at or before the job being inserted
      job_type job;
   } link_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      job_type     new_job;
   } queue_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REINS,
      ST_RESULT
   } state_type;

   // Sort key: priority, then id. Equal keys keep their entry order.
   function automatic logic key_le(input job_type a, input job_type b);
      return {a.prio, a.id} <= {b.prio, b.id};
   endfunction

endpackage

// File: hdl/ppsch_cell.sv
// One slot of the sorted ready queue: holds a job and trades it with neighbors.
// Depends on ppsch_pkg.
module ppsch_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ppsch_pkg::cell_op_type op,
   input  ppsch_pkg::job_type     new_job,
   input  ppsch_pkg::link_type    prev_link,
   input  ppsch_pkg::link_type    next_link,
   output ppsch_pkg::link_type    link
);
   import ppsch_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    le;

   assign le = valid_ff && key_le(job_ff, new_job);

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      unique case (op)
         OP_POP: begin
            valid_in = next_link.valid;
            job_in   = next_link.job;
         end
         OP_INSERT: begin
            // stable insert: new job lands behind every job that sorts at or before it
            if (!le) begin
               if (prev_link.le) begin
                  valid_in = 1'b1;
                  job_in   = new_job;
               end else begin
                  valid_in = prev_link.valid;
                  job_in   = prev_link.job;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign link = '{valid: valid_ff, le: le, job: job_ff};

endmodule

// File: hdl/ppsch_queue.sv
// Ready queue as a chain of cells kept sorted, best job always in cell 0.
// Depends on ppsch_pkg and ppsch_cell.
module ppsch_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  ppsch_pkg::queue_cmd_type cmd,
   output ppsch_pkg::job_type       head
);
   import ppsch_pkg::*;

   localparam link_type LINK_HEAD = '{valid: 1'b0, le: 1'b1, job: '0};
   localparam link_type LINK_TAIL = '{valid: 1'b0, le: 1'b0, job: '0};

   link_type links     [QUEUE_DEPTH];
   link_type prev_link [QUEUE_DEPTH];
   link_type next_link [QUEUE_DEPTH];

   for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
         assign prev_link[gi] = LINK_HEAD;
      end else begin : g_mid
         assign prev_link[gi] = links[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
         assign next_link[gi] = LINK_TAIL;
      end else begin : g_body
         assign next_link[gi] = links[gi+1];
      end

      ppsch_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (cmd.op),
         .new_job   (cmd.new_job),
         .prev_link (prev_link[gi]),
         .next_link (next_link[gi]),
         .link      (links[gi])
      );
   end

   assign head = links[0].job;

endmodule

// File: hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: one result transaction per request transaction.
// An arrival, a halted tick or a tick without preemption passes through ST_EXEC and
// ST_RESULT; a tick that preempts also passes through ST_REINS, which puts the
// preempted job back through the cell chain. A result transaction not taken holds
// the block before the next. Arrivals go to a sorted queue of QUEUE_DEPTH cells
// (lower priority value first, then lower id, then entry order); a full queue drops them and flags it.
// Depends on ppsch_pkg and ppsch_queue.
module preemptive_priority_scheduler (
   input  logic                                 clock,
   input  logic                                 reset,
   // halted
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_data,
   // job_id[7:0], job_priority[15:8], job_burst[31:16]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ppsch_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // kind[0]
   input  logic                                 req_tuser,
   // running_valid[0], running_id[8:1], finished[9], finished_id[17:10],
   // finish_time[49:18], dropped[50], waiting_count[55:51], busy_ticks[87:56]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ppsch_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import ppsch_pkg::*;

   state_type             state_ff, state_in;
   logic                  halted_ff;
   logic                  kind_ff;
   job_type               item_job_ff;
   logic                  cur_valid_ff, cur_valid_in;
   job_type               cur_job_ff, cur_job_in;
   job_type               held_job_ff, held_job_in;
   logic [COUNT_BITS-1:0] time_ff, time_in;
   logic [COUNT_BITS-1:0] busy_ff, busy_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic                  fin_ff, fin_in;
   logic [ID_BITS-1:0]    fin_id_ff, fin_id_in;
   logic [COUNT_BITS-1:0] fin_time_ff, fin_time_in;
   logic                  drop_ff, drop_in;
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff;

   job_type       head;
   queue_cmd_type cmd;
   logic          out_free, load_out, accept;
   logic          full, has_waiting, preempt, tick_run;
   job_type       eff_job;

   assign out_free    = !rsp_tvalid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign full        = fill_ff >= FILL_BITS'(QUEUE_DEPTH);
   assign has_waiting = fill_ff != '0;
   assign preempt     = cur_valid_ff && has_waiting && (head.prio < cur_job_ff.prio);
   assign tick_run    = (kind_ff == KIND_TICK) && !halted_ff;
   assign eff_job     = preempt ? head : cur_job_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (tick_run && preempt) ? ST_REINS : ST_RESULT;
         end
         ST_REINS: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) state_in = req_tvalid ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = 1'b0;
      load_out    = 1'b0;
      cmd.op      = OP_HOLD;
      cmd.new_job = item_job_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_EXEC: begin
            if (kind_ff == KIND_ARRIVAL) begin
               if (!full) cmd.op = OP_INSERT;
            end else if (tick_run && (preempt || (!cur_valid_ff && has_waiting))) begin
               cmd.op = OP_POP;
            end
         end
         ST_REINS: begin
            cmd.op      = OP_INSERT;
            cmd.new_job = held_job_ff;
         end
         ST_RESULT: begin
            req_tready = out_free;
            load_out   = out_free;
         end
         default: begin
         end
      endcase
   end

   // scheduling datapath
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_job_in   = cur_job_ff;
      held_job_in  = held_job_ff;
      time_in      = time_ff;
      busy_in      = busy_ff;
      fill_in      = fill_ff;
      fin_in       = fin_ff;
      fin_id_in    = fin_id_ff;
      fin_time_in  = fin_time_ff;
      drop_in      = drop_ff;
      if (state_ff == ST_EXEC) begin
         fin_in      = 1'b0;
         fin_id_in   = '0;
         fin_time_in = '0;
         drop_in     = 1'b0;
         if (kind_ff == KIND_ARRIVAL) begin
            if (full) drop_in = 1'b1;
            else      fill_in = fill_ff + 1'b1;
         end else if (tick_run) begin
            time_in = time_ff + 1'b1;
            if (cur_valid_ff) begin
               held_job_in = cur_job_ff;   // preempted job, reinserted next cycle
               busy_in     = busy_ff + 1'b1;
               if (eff_job.rem <= BURST_BITS'(1)) begin
                  fin_in       = 1'b1;
                  fin_id_in    = eff_job.id;
                  fin_time_in  = time_ff;
                  cur_valid_in = 1'b0;
                  cur_job_in   = eff_job;
               end else begin
                  cur_job_in     = eff_job;
                  cur_job_in.rem = eff_job.rem - 1'b1;
               end
            end else if (has_waiting) begin
               cur_job_in   = head;
               cur_valid_in = 1'b1;
               fill_in      = fill_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         halted_ff     <= 1'b0;
         cur_valid_ff  <= 1'b0;
         time_ff       <= '0;
         busy_ff       <= '0;
         fill_ff       <= '0;
         fin_ff        <= 1'b0;
         drop_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid) halted_ff <= csr_data;
         cur_valid_ff <= cur_valid_in;
         time_ff      <= time_in;
         busy_ff      <= busy_in;
         fill_ff      <= fill_in;
         fin_ff       <= fin_in;
         drop_ff      <= drop_in;
         if (load_out)        rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff          <= req_tuser;
         item_job_ff.id   <= ID_BITS'(req_tdata[7:0]);
         item_job_ff.prio <= PRIO_BITS'(req_tdata[15:8]);
         item_job_ff.rem  <= BURST_BITS'(req_tdata[31:16]);
      end
      cur_job_ff  <= cur_job_in;
      held_job_ff <= held_job_in;
      fin_id_ff   <= fin_id_in;
      fin_time_ff <= fin_time_in;
      if (load_out) begin
         rsp_tdata_ff <= {busy_ff, 5'(fill_ff), drop_ff, fin_time_ff, 8'(fin_id_ff), fin_ff,
                          (cur_valid_ff ? 8'(cur_job_ff.id) : 8'd0), cur_valid_ff};
      end
   end

   ppsch_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .head  (head)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: hdl/ppsch_checker.sv
// Port-level checks for the preemptive priority scheduler, bound to the top level.
// Depends on ppsch_pkg and preemptive_priority_scheduler.
module ppsch_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ppsch_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import ppsch_pkg::*;

   // a result transaction holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result transaction dropped before it was taken");

   // one request transaction at a time: the block is busy the cycle after
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request transaction accepted while previous one in flight");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:51] <= 5'(QUEUE_DEPTH))
      else $error("waiting count above queue depth");

   // a finishing tick dispatches nothing
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> !rsp_tdata[0] && !rsp_tdata[50])
      else $error("job running or drop flagged on a finishing tick");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[9] |-> rsp_tdata[17:10] == '0 && rsp_tdata[49:18] == '0)
      else $error("finish fields set without a finish");

endmodule

bind preemptive_priority_scheduler ppsch_checker u_checker (.*);
